@@ design/svps_pkg.sv @@
// shared types and constants for the snapshot visible page seek block
// no dependencies
`default_nettype none

package svps_pkg;

    localparam int PAGE_ENTRIES = 256;
    localparam int POS_W        = $clog2(PAGE_ENTRIES);
    localparam int CNT_W        = POS_W + 1;
    localparam int KEY_W        = 64;
    localparam int VER_W        = 64;
    localparam int CFG_W        = 64;

    // item modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_SEEK = 2'd1;
    localparam logic [1:0] MODE_NEXT = 2'd2;

    // seek orders
    localparam logic [2:0] ORD_LT     = 3'd0;
    localparam logic [2:0] ORD_LTE    = 3'd1;
    localparam logic [2:0] ORD_GT     = 3'd2;
    localparam logic [2:0] ORD_GTE    = 3'd3;
    localparam logic [2:0] ORD_EQ     = 3'd4;
    localparam logic [2:0] ORD_UPDATE = 3'd5;

    // configuration register indexes
    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_PAGE_MIN    = 1'b1;

    typedef struct packed {
        logic             dup;
        logic [VER_W-1:0] version;
        logic [KEY_W-1:0] key;
    } entry_t;

endpackage

`default_nettype wire

@@ design/svps_entry_mem.sv @@
// page entry memory: one write port, one read port with registered data
// depends on svps_pkg
`default_nettype none

module svps_entry_mem
    import svps_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [POS_W-1:0] wr_addr,
    input  wire entry_t           wr_data,
    input  wire logic [POS_W-1:0] rd_addr,
    output entry_t                rd_data
);

    entry_t mem [PAGE_ENTRIES];

    // synchronous write and read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ design/snapshot_visible_page_seek.sv @@
// snapshot visible page seek: sequencer over the entry memory
// depends on svps_pkg and svps_entry_mem
// a load writes its entry and goes to done; a seek runs up to log2(entries) + 1 search probes
// when a key is present, then chain walks; a next runs chain walks; each walk step is one memory read per cycle
// throughput: one item at a time, set by the sequencer (ready only in idle); a held result stalls the next
// reset: synchronous active low aresetn clears cursor, order, snapshot and config;
// the entry memory is not cleared and needs no clearing pass
`default_nettype none

module snapshot_visible_page_seek
    import svps_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // configuration
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    // input items
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_mode,
    input  wire logic [POS_W-1:0] s_entry_index,
    input  wire logic [KEY_W-1:0] s_entry_key,
    input  wire logic [VER_W-1:0] s_entry_version,
    input  wire logic             s_entry_is_dup,
    input  wire logic [2:0]       s_seek_order,
    input  wire logic             s_key_present,
    input  wire logic [KEY_W-1:0] s_search_key,
    input  wire logic [VER_W-1:0] s_snapshot_version,
    // result items
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_found,
    output logic [POS_W-1:0]      m_position,
    output logic                  m_exact_match,
    output logic                  m_bad_request
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BS   = 4'd1;
    localparam logic [3:0] S_LL0  = 4'd2;
    localparam logic [3:0] S_LLUP = 4'd3;
    localparam logic [3:0] S_LV   = 4'd4;
    localparam logic [3:0] S_UV   = 4'd5;
    localparam logic [3:0] S_LH0  = 4'd6;
    localparam logic [3:0] S_LHDN = 4'd7;
    localparam logic [3:0] S_CMP  = 4'd8;
    localparam logic [3:0] S_SB   = 4'd9;
    localparam logic [3:0] S_SF   = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    localparam logic [CNT_W-1:0] PAGE_CNT = CNT_W'(PAGE_ENTRIES);

    // config registers
    logic [CNT_W-1:0] count_reg;
    logic [VER_W-1:0] pmin_reg;

    // architectural state
    logic [3:0]       state_reg, state_next;
    logic [POS_W-1:0] cur_reg, cur_next;
    logic             cur_vld_reg, cur_vld_next;
    logic [2:0]       order_reg, order_next;
    logic [VER_W-1:0] snap_reg, snap_next;

    // working registers
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [POS_W-1:0] hi_reg, hi_next;
    logic [POS_W-1:0] base_reg, base_next;
    logic [POS_W-1:0] best_reg, best_next;
    logic             best_vld_reg, best_vld_next;
    logic             ret_cmp_reg, ret_cmp_next;
    logic             low_reg, low_next;
    logic             incl_reg, incl_next;
    logic             upd_reg, upd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VER_W-1:0] osnap_reg, osnap_next;
    logic             exact_reg, exact_next;
    logic             bad_reg, bad_next;

    // output register
    logic             m_valid_reg;
    logic             m_found_reg;
    logic [POS_W-1:0] m_pos_reg;
    logic             m_exact_reg;
    logic             m_bad_reg;

    entry_t           rd;
    entry_t           wr_data;
    logic             accept;
    logic             wr_en;
    logic [CNT_W-1:0] n_cnt;

    assign n_cnt   = (count_reg > PAGE_CNT) ? PAGE_CNT : count_reg;
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign wr_en   = accept && (s_mode == MODE_LOAD);
    assign wr_data = '{dup: s_entry_is_dup, version: s_entry_version, key: s_entry_key};

    // entry memory, read address follows the next walk position
    svps_entry_mem u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_entry_index),
        .wr_data (wr_data),
        .rd_addr (pos_next),
        .rd_data (rd)
    );

    // sequencer
    always_comb begin
        logic             fin;
        logic             vis;
        logic             k_eq;
        logic             k_lt;
        logic [CNT_W-1:0] p1;
        logic [CNT_W-1:0] mid;
        logic [POS_W-1:0] nb;
        logic             nb_vld;
        logic [CNT_W-1:0] lo_n;
        logic             more;
        logic [2:0]       ord;

        state_next    = state_reg;
        cur_next      = cur_reg;
        cur_vld_next  = cur_vld_reg;
        order_next    = order_reg;
        snap_next     = snap_reg;
        pos_next      = pos_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        base_next     = base_reg;
        best_next     = best_reg;
        best_vld_next = best_vld_reg;
        ret_cmp_next  = ret_cmp_reg;
        low_next      = low_reg;
        incl_next     = incl_reg;
        upd_next      = upd_reg;
        key_next      = key_reg;
        osnap_next    = osnap_reg;
        exact_next    = exact_reg;
        bad_next      = bad_reg;
        fin           = 1'b0;
        vis           = (rd.version <= snap_reg);
        k_eq          = (rd.key == key_reg);
        k_lt          = (rd.key < key_reg);
        p1            = {1'b0, pos_reg} + 1'b1;
        mid           = '0;
        nb            = vis ? pos_reg : best_reg;
        nb_vld        = vis || best_vld_reg;
        lo_n          = lo_reg;
        more          = 1'b0;
        ord           = s_seek_order;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    exact_next = 1'b0;
                    bad_next   = 1'b0;
                    state_next = S_DONE;
                    case (s_mode)
                        MODE_SEEK: begin
                            order_next   = ord;
                            snap_next    = (ord == ORD_UPDATE) ? '1 : s_snapshot_version;
                            osnap_next   = s_snapshot_version;
                            key_next     = s_search_key;
                            low_next     = !(ord == ORD_GT || ord == ORD_GTE);
                            incl_next    = !(ord == ORD_LT || ord == ORD_GT);
                            upd_next     = (ord == ORD_UPDATE);
                            cur_vld_next = 1'b0;
                            cur_next     = '0;
                            best_vld_next = 1'b0;
                            if (ord > ORD_UPDATE || n_cnt == '0 ||
                                (pmin_reg > s_snapshot_version && ord != ORD_UPDATE)) begin
                                state_next = S_DONE;
                            end else if (!s_key_present) begin
                                ret_cmp_next = 1'b0;
                                if (ord == ORD_GT || ord == ORD_GTE) begin
                                    pos_next   = '0;
                                    state_next = S_UV;
                                end else begin
                                    pos_next   = POS_W'(n_cnt - 1'b1);
                                    state_next = S_LV;
                                end
                            end else begin
                                ret_cmp_next = 1'b1;
                                lo_next      = '0;
                                hi_next      = POS_W'(n_cnt - 1'b1);
                                pos_next     = POS_W'((n_cnt - 1'b1) >> 1);
                                state_next   = S_BS;
                            end
                        end
                        MODE_NEXT: begin
                            ret_cmp_next  = 1'b0;
                            best_vld_next = 1'b0;
                            if (order_reg > ORD_GTE) begin
                                bad_next = 1'b1;
                            end else if (!cur_vld_reg || {1'b0, cur_reg} >= n_cnt) begin
                                cur_vld_next = 1'b0;
                                cur_next     = '0;
                            end else if (order_reg <= ORD_LTE) begin
                                pos_next   = cur_reg;
                                state_next = S_SB;
                            end else if ({1'b0, cur_reg} + 1'b1 >= n_cnt) begin
                                cur_vld_next = 1'b0;
                                cur_next     = '0;
                            end else begin
                                pos_next   = cur_reg + 1'b1;
                                state_next = S_SF;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // binary search probe at pos
            S_BS: begin
                if (k_eq) begin
                    lo_n = {1'b0, pos_reg};
                end else if (k_lt) begin
                    lo_n = p1;
                    more = (p1 <= {1'b0, hi_reg});
                    if (more) begin
                        mid = (p1 + {1'b0, hi_reg}) >> 1;
                    end
                end else begin
                    more = (pos_reg != '0) && ((pos_reg - 1'b1) >= POS_W'(lo_reg));
                    if (pos_reg != '0) begin
                        hi_next = pos_reg - 1'b1;
                        mid     = (lo_reg + {1'b0, pos_reg - 1'b1}) >> 1;
                    end
                end
                lo_next = lo_n;
                if (more) begin
                    pos_next = POS_W'(mid);
                end else begin
                    pos_next   = (lo_n >= n_cnt) ? POS_W'(n_cnt - 1'b1) : POS_W'(lo_n);
                    state_next = low_reg ? S_LL0 : S_LH0;
                end
            end

            // land low: check the hit itself
            S_LL0: begin
                cur_vld_next  = 1'b1;
                cur_next      = pos_reg;
                best_vld_next = 1'b0;
                if (rd.version == snap_reg) begin
                    fin = 1'b1;
                end else if (rd.version > snap_reg && p1 < n_cnt) begin
                    base_next  = pos_reg;
                    pos_next   = POS_W'(p1);
                    state_next = S_LLUP;
                end else begin
                    state_next = S_LV;
                end
            end

            // land low: scan the following duplicates
            S_LLUP: begin
                if (rd.dup && vis) begin
                    cur_next = pos_reg;
                    fin      = 1'b1;
                end else if (rd.dup && p1 < n_cnt) begin
                    pos_next = POS_W'(p1);
                end else begin
                    best_vld_next = 1'b0;
                    pos_next      = base_reg;
                    state_next    = S_LV;
                end
            end

            // walk down to lowest visible slot of nearest chain
            S_LV: begin
                best_next     = nb;
                best_vld_next = nb_vld;
                if (!rd.dup && nb_vld) begin
                    cur_vld_next = 1'b1;
                    cur_next     = nb;
                    fin          = 1'b1;
                end else if (pos_reg == '0) begin
                    cur_vld_next = 1'b0;
                    cur_next     = '0;
                    fin          = 1'b1;
                end else begin
                    pos_next = pos_reg - 1'b1;
                end
            end

            // walk up to first visible slot
            S_UV: begin
                if (vis) begin
                    cur_vld_next = 1'b1;
                    cur_next     = pos_reg;
                    fin          = 1'b1;
                end else if (p1 >= n_cnt) begin
                    cur_vld_next = 1'b0;
                    cur_next     = '0;
                    fin          = 1'b1;
                end else begin
                    pos_next = POS_W'(p1);
                end
            end

            // land high: check the hit itself
            S_LH0: begin
                cur_vld_next = 1'b1;
                cur_next     = pos_reg;
                if (rd.version == snap_reg) begin
                    fin = 1'b1;
                end else if (rd.version > snap_reg) begin
                    if (p1 >= n_cnt) begin
                        cur_vld_next = 1'b0;
                        cur_next     = '0;
                        fin          = 1'b1;
                    end else begin
                        pos_next   = POS_W'(p1);
                        state_next = S_UV;
                    end
                end else if (!rd.dup || pos_reg == '0) begin
                    fin = 1'b1;
                end else begin
                    best_next  = pos_reg;
                    pos_next   = pos_reg - 1'b1;
                    state_next = S_LHDN;
                end
            end

            // land high: lowest visible slot of this chain
            S_LHDN: begin
                best_next = nb;
                if (!rd.dup || pos_reg == '0) begin
                    cur_next = nb;
                    fin      = 1'b1;
                end else begin
                    pos_next = pos_reg - 1'b1;
                end
            end

            // compare landed key and decide on a step
            S_CMP: begin
                exact_next   = k_eq && (!upd_reg || rd.version > osnap_reg);
                ret_cmp_next = 1'b0;
                if (low_reg && ((k_eq && !incl_reg) || (!k_eq && !k_lt))) begin
                    best_vld_next = 1'b0;
                    state_next    = S_SB;
                end else if (!low_reg && ((k_eq && !incl_reg) || k_lt)) begin
                    if (p1 >= n_cnt) begin
                        cur_vld_next = 1'b0;
                        cur_next     = '0;
                        state_next   = S_DONE;
                    end else begin
                        pos_next   = POS_W'(p1);
                        state_next = S_SF;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end

            // step back: skip own chain then walk down
            S_SB: begin
                if (pos_reg == '0) begin
                    cur_vld_next = 1'b0;
                    cur_next     = '0;
                    state_next   = S_DONE;
                end else begin
                    pos_next = pos_reg - 1'b1;
                    if (!rd.dup) begin
                        best_vld_next = 1'b0;
                        state_next    = S_LV;
                    end
                end
            end

            // step forward: skip duplicates then walk up
            S_SF: begin
                if (!rd.dup) begin
                    state_next = S_UV;
                end else if (p1 >= n_cnt) begin
                    cur_vld_next = 1'b0;
                    cur_next     = '0;
                    state_next   = S_DONE;
                end else begin
                    pos_next = POS_W'(p1);
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // return from a walk
        if (fin) begin
            if (ret_cmp_reg && cur_vld_next) begin
                pos_next   = cur_next;
                state_next = S_CMP;
            end else begin
                state_next = S_DONE;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cur_reg     <= '0;
            cur_vld_reg <= 1'b0;
            order_reg   <= ORD_LT;
            snap_reg    <= '0;
            count_reg   <= '0;
            pmin_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            cur_vld_reg <= cur_vld_next;
            order_reg   <= order_next;
            snap_reg    <= snap_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ENTRY_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                    CFG_PAGE_MIN:    pmin_reg  <= cfg_data[VER_W-1:0];
                    default:         count_reg <= count_reg;
                endcase
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working and result payload registers
    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        base_reg     <= base_next;
        best_reg     <= best_next;
        best_vld_reg <= best_vld_next;
        ret_cmp_reg  <= ret_cmp_next;
        low_reg      <= low_next;
        incl_reg     <= incl_next;
        upd_reg      <= upd_next;
        key_reg      <= key_next;
        osnap_reg    <= osnap_next;
        exact_reg    <= exact_next;
        bad_reg      <= bad_next;
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_found_reg <= cur_vld_reg;
            m_pos_reg   <= cur_vld_reg ? cur_reg : '0;
            m_exact_reg <= exact_reg;
            m_bad_reg   <= bad_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_position    = m_pos_reg;
    assign m_exact_match = m_exact_reg;
    assign m_bad_request = m_bad_reg;

endmodule

`default_nettype wire

@@ test/tb_snapshot_visible_page_seek.sv @@
// self-checking testbench for snapshot_visible_page_seek: directed and random items
// depends on svps_pkg and the block under test; the scoreboard class predicts each result
`timescale 1ns / 1ps

module tb_snapshot_visible_page_seek;
    import svps_pkg::*;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             exact_match;
        logic             bad_request;
    } seek_result_t;

    // predictor of the page and cursor plus the store of expected results
    class seek_scoreboard;
        logic [KEY_W-1:0] keys [PAGE_ENTRIES];
        logic [VER_W-1:0] vers [PAGE_ENTRIES];
        bit               dups [PAGE_ENTRIES];
        int               cur_pos;
        bit               cur_valid;
        logic [2:0]       act_order;
        logic [VER_W-1:0] act_snap;
        logic [8:0]       entry_count;
        logic [VER_W-1:0] page_min;
        seek_result_t     expected_q[$];
        int               mismatches;
        int               results_seen;

        function new();
            for (int i = 0; i < PAGE_ENTRIES; i++) begin
                keys[i] = '0;
                vers[i] = '0;
                dups[i] = 0;
            end
            cur_pos = 0;
            cur_valid = 0;
            act_order = ORD_LT;
            act_snap = '0;
            entry_count = '0;
            page_min = '0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] data);
            if (idx == CFG_ENTRY_COUNT) entry_count = data[8:0];
            else page_min = data;
        endfunction

        function int used_slots();
            return (entry_count > PAGE_ENTRIES) ? PAGE_ENTRIES : int'(entry_count);
        endfunction

        function void park();
            cur_valid = 0;
            cur_pos = 0;
        endfunction

        function void place(int p);
            cur_valid = 1;
            cur_pos = p;
        endfunction

        function int cmp_key(int p, logic [KEY_W-1:0] k);
            if (keys[p] < k) return -1;
            if (keys[p] > k) return 1;
            return 0;
        endfunction

        function int first_not_below(int n, logic [KEY_W-1:0] k);
            int lo, hi, mid, rc;
            lo = 0;
            hi = n - 1;
            while (hi >= lo) begin
                mid = lo + (hi - lo) / 2;
                rc = cmp_key(mid, k);
                if (rc < 0) lo = mid + 1;
                else if (rc > 0) hi = mid - 1;
                else return mid;
            end
            return lo;
        endfunction

        // walk down to the lowest visible slot of the nearest chain holding one
        function void walk_down(int p, logic [VER_W-1:0] snap);
            int best;
            best = -1;
            while (p >= 0) begin
                if (vers[p] <= snap) best = p;
                if (!dups[p] && best >= 0) begin
                    place(best);
                    return;
                end
                p--;
            end
            park();
        endfunction

        function void walk_up(int p, int n, logic [VER_W-1:0] snap);
            while (p < n) begin
                if (vers[p] <= snap) begin
                    place(p);
                    return;
                end
                p++;
            end
            park();
        endfunction

        function void settle_low(int p, int n, logic [VER_W-1:0] snap);
            place(p);
            if (vers[p] == snap) return;
            if (vers[p] > snap) begin
                for (int q = p + 1; q < n && dups[q]; q++) begin
                    if (vers[q] <= snap) begin
                        place(q);
                        return;
                    end
                end
            end
            walk_down(p, snap);
        endfunction

        function void settle_high(int p, int n, logic [VER_W-1:0] snap);
            int best;
            place(p);
            if (vers[p] == snap) return;
            if (vers[p] > snap) begin
                walk_up(p + 1, n, snap);
                return;
            end
            if (!dups[p]) return;
            best = p;
            for (int q = p - 1; q >= 0; q--) begin
                if (vers[q] <= snap) best = q;
                if (!dups[q]) break;
            end
            place(best);
        endfunction

        function void move_back(logic [VER_W-1:0] snap);
            int p;
            p = cur_pos;
            if (dups[p]) begin
                p--;
                while (p >= 0 && dups[p]) p--;
                if (p < 0) begin
                    park();
                    return;
                end
            end
            walk_down(p - 1, snap);
        endfunction

        function void move_fwd(int n, logic [VER_W-1:0] snap);
            int p;
            p = cur_pos + 1;
            while (p < n && dups[p]) p++;
            if (p >= n) begin
                park();
                return;
            end
            walk_up(p, n, snap);
        endfunction

        function bit seek_down(bit incl, bit has_key, logic [KEY_W-1:0] k,
                               logic [VER_W-1:0] snap);
            int n, p, rc;
            n = used_slots();
            if (n == 0) begin
                park();
                return 0;
            end
            if (!has_key) begin
                walk_down(n - 1, snap);
                return 0;
            end
            p = first_not_below(n, k);
            if (p >= n) p = n - 1;
            settle_low(p, n, snap);
            if (!cur_valid) return 0;
            rc = cmp_key(cur_pos, k);
            if ((rc == 0 && !incl) || rc > 0) move_back(snap);
            return rc == 0;
        endfunction

        function bit seek_up(bit incl, bit has_key, logic [KEY_W-1:0] k,
                             logic [VER_W-1:0] snap);
            int n, p, rc;
            n = used_slots();
            if (n == 0) begin
                park();
                return 0;
            end
            if (!has_key) begin
                walk_up(0, n, snap);
                return 0;
            end
            p = first_not_below(n, k);
            if (p >= n) p = n - 1;
            settle_high(p, n, snap);
            if (!cur_valid) return 0;
            rc = cmp_key(cur_pos, k);
            if ((rc == 0 && !incl) || rc < 0) move_fwd(n, snap);
            return rc == 0;
        endfunction

        // predict the result of one accepted item
        function void note_item(logic [1:0] mode, logic [POS_W-1:0] idx,
                                logic [KEY_W-1:0] ekey, logic [VER_W-1:0] ever, bit edup,
                                logic [2:0] order, bit has_key, logic [KEY_W-1:0] skey,
                                logic [VER_W-1:0] snap);
            bit exact, bad, m;
            int n;
            seek_result_t r;
            exact = 0;
            bad = 0;
            if (mode == MODE_LOAD) begin
                keys[idx] = ekey;
                vers[idx] = ever;
                dups[idx] = edup;
            end else if (mode == MODE_SEEK) begin
                act_order = order;
                act_snap = (order == ORD_UPDATE) ? '1 : snap;
                park();
                if (order <= ORD_UPDATE && !(page_min > snap && order != ORD_UPDATE)) begin
                    case (order)
                        ORD_LT:  exact = seek_down(0, has_key, skey, snap);
                        ORD_LTE: exact = seek_down(1, has_key, skey, snap);
                        ORD_GT:  exact = seek_up(0, has_key, skey, snap);
                        ORD_GTE: exact = seek_up(1, has_key, skey, snap);
                        ORD_EQ:  exact = seek_down(1, has_key, skey, snap);
                        default: begin
                            m = seek_down(1, has_key, skey, '1);
                            exact = m && cur_valid && vers[cur_pos] > snap;
                        end
                    endcase
                end
            end else if (mode == MODE_NEXT) begin
                n = used_slots();
                if (act_order > ORD_GTE) bad = 1;
                else if (!cur_valid || cur_pos >= n) park();
                else if (act_order <= ORD_LTE) move_back(act_snap);
                else move_fwd(n, act_snap);
            end
            r.found = cur_valid;
            r.position = cur_valid ? cur_pos[POS_W-1:0] : '0;
            r.exact_match = exact;
            r.bad_request = bad;
            expected_q.push_back(r);
        endfunction

        function void check_result(seek_result_t got);
            seek_result_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: %p", $realtime, got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             s_valid;
    logic             s_ready;
    logic [1:0]       s_mode;
    logic [POS_W-1:0] s_entry_index;
    logic [KEY_W-1:0] s_entry_key;
    logic [VER_W-1:0] s_entry_version;
    logic             s_entry_is_dup;
    logic [2:0]       s_seek_order;
    logic             s_key_present;
    logic [KEY_W-1:0] s_search_key;
    logic [VER_W-1:0] s_snapshot_version;
    logic             m_valid;
    logic             m_ready;
    logic             m_found;
    logic [POS_W-1:0] m_position;
    logic             m_exact_match;
    logic             m_bad_request;

    seek_scoreboard   sb;
    logic [KEY_W-1:0] page_keys [PAGE_ENTRIES];
    bit               loaded [PAGE_ENTRIES];
    int               page_size;
    int               items_sent;
    int               phases;
    bit               calm;
    int               stall_left;

    snapshot_visible_page_seek DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_entry_index(s_entry_index), .s_entry_key(s_entry_key),
        .s_entry_version(s_entry_version), .s_entry_is_dup(s_entry_is_dup),
        .s_seek_order(s_seek_order), .s_key_present(s_key_present),
        .s_search_key(s_search_key), .s_snapshot_version(s_snapshot_version),
        .m_valid(m_valid), .m_ready(m_ready), .m_found(m_found),
        .m_position(m_position), .m_exact_match(m_exact_match),
        .m_bad_request(m_bad_request)
    );

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // watchdog
    initial begin
        #100ms;
        $display("FAIL snapshot_visible_page_seek");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            stall_left <= gap_len();
            m_ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_found, m_position, m_exact_match, m_bad_request});
    end

    task automatic send_item(logic [1:0] mode, logic [POS_W-1:0] idx, logic [KEY_W-1:0] ekey,
                             logic [VER_W-1:0] ever, bit edup, logic [2:0] order,
                             bit has_key, logic [KEY_W-1:0] skey, logic [VER_W-1:0] snap);
        int g;
        s_valid <= 1'b1;
        s_mode <= mode;
        s_entry_index <= idx;
        s_entry_key <= ekey;
        s_entry_version <= ever;
        s_entry_is_dup <= edup;
        s_seek_order <= order;
        s_key_present <= has_key;
        s_search_key <= skey;
        s_snapshot_version <= snap;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(mode, idx, ekey, ever, edup, order, has_key, skey, snap);
        if (mode == MODE_LOAD) begin
            loaded[idx] = 1;
            page_keys[idx] = ekey;
        end
        items_sent++;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic load_entry(int idx, logic [KEY_W-1:0] k, logic [VER_W-1:0] v, bit d);
        send_item(MODE_LOAD, idx[POS_W-1:0], k, v, d, 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)), rand64(), rand64());
    endtask

    task automatic do_seek(logic [2:0] order, bit has_key, logic [KEY_W-1:0] k,
                           logic [VER_W-1:0] snap);
        send_item(MODE_SEEK, POS_W'($urandom_range(0, 255)), rand64(), rand64(),
                  1'($urandom_range(0, 1)), order, has_key, k, snap);
    endtask

    task automatic do_next(logic [1:0] mode);
        send_item(mode, POS_W'($urandom_range(0, 255)), rand64(), rand64(),
                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)), rand64(), rand64());
    endtask

    // idle point: every result in, then a wait for the block to settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // sorted page with duplicate chains, keys near the bottom, top or anywhere
    task automatic build_page(int n);
        logic [KEY_W-1:0] k;
        logic [VER_W-1:0] v;
        bit d;
        int sel;
        sel = $urandom_range(0, 2);
        k = (sel == 0) ? 64'd0 : (sel == 1) ? ('1 - 64'(4 * n)) : rand64();
        for (int i = 0; i < n; i++) begin
            d = (i == 0) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 2) == 0);
            if (i > 0 && !d) k = k + 64'($urandom_range(1, 3));
            sel = $urandom_range(0, 19);
            v = (sel == 0) ? '1 : (sel == 1) ? 64'd0 : 64'($urandom_range(0, 15));
            load_entry(i, k, v, d);
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int sel, p;
        sel = $urandom_range(0, 9);
        if (page_size > 0 && sel < 7) begin
            p = $urandom_range(0, page_size - 1);
            return page_keys[p] + 64'($urandom_range(0, 2)) - 64'd1;
        end
        if (sel == 7) return 64'd0;
        if (sel == 8) return '1;
        return rand64();
    endfunction

    function automatic logic [VER_W-1:0] pick_snap();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return '1;
        if (sel == 1) return 64'd0;
        if (sel == 2) return rand64();
        return 64'($urandom_range(0, 17));
    endfunction

    task automatic random_phase();
        int n, cnt, sel, len;
        logic [2:0] order;
        drain();
        sel = $urandom_range(0, 99);
        if (sel < 5) n = 0;
        else if (sel < 70) n = $urandom_range(1, 12);
        else if (sel < 90) n = $urandom_range(13, 40);
        else n = PAGE_ENTRIES;
        if (n > 0 && ($urandom_range(0, 3) != 0 || !loaded[n - 1])) build_page(n);
        cnt = n;
        if (n == PAGE_ENTRIES && $urandom_range(0, 1)) cnt = $urandom_range(257, 511);
        for (int i = 0; i < n; i++)
            if (!loaded[i]) cnt = 0;
        page_size = (cnt > PAGE_ENTRIES) ? PAGE_ENTRIES : cnt;
        drain();
        write_reg(CFG_ENTRY_COUNT, CFG_W'(cnt));
        sel = $urandom_range(0, 9);
        write_reg(CFG_PAGE_MIN, (sel < 6) ? 64'd0 : (sel < 9) ? 64'($urandom_range(0, 8)) : '1);
        calm = ($urandom_range(0, 4) == 0);
        phases++;
        len = $urandom_range(20, 60);
        for (int i = 0; i < len; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                order = (sel < 3) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
                do_seek(order, $urandom_range(0, 7) != 0, pick_key(), pick_snap());
            end else if (sel < 88) begin
                do_next(MODE_NEXT);
            end else if (sel < 95) begin
                // stray load anywhere: may break the sort order, the block must still agree
                load_entry($urandom_range(0, 255), pick_key(), pick_snap(),
                           1'($urandom_range(0, 1)));
            end else begin
                do_next(2'd3);
            end
        end
    endtask

    initial begin
        sb = new();
        items_sent = 0;
        phases = 0;
        calm = 0;
        page_size = 0;
        for (int i = 0; i < PAGE_ENTRIES; i++) begin
            loaded[i] = 0;
            page_keys[i] = '0;
        end
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_ENTRY_COUNT;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_mode <= MODE_LOAD;
        s_entry_index <= '0;
        s_entry_key <= '0;
        s_entry_version <= '0;
        s_entry_is_dup <= 1'b0;
        s_seek_order <= ORD_LT;
        s_key_present <= 1'b0;
        s_search_key <= '0;
        s_snapshot_version <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty page, then a small page with extreme keys and chains
        do_seek(ORD_GTE, 1, 64'd5, 64'd3);
        do_next(MODE_NEXT);
        load_entry(0, 64'd0, 64'd2, 1);
        load_entry(1, 64'd0, 64'd0, 1);
        load_entry(2, 64'd7, 64'd9, 0);
        load_entry(3, 64'd7, 64'd4, 1);
        load_entry(4, '1, '1, 0);
        load_entry(5, '1, 64'd1, 1);
        page_size = 6;
        drain();
        write_reg(CFG_ENTRY_COUNT, CFG_W'(6));
        write_reg(CFG_PAGE_MIN, 64'd0);
        do_seek(ORD_LT, 1, 64'd7, 64'd4);
        do_next(MODE_NEXT);
        do_seek(ORD_LTE, 0, '1, 64'd5);
        do_seek(ORD_GT, 1, 64'd0, 64'd4);
        do_next(MODE_NEXT);
        do_next(MODE_NEXT);
        do_seek(ORD_GTE, 0, 64'd0, '1);
        do_seek(ORD_EQ, 1, '1, 64'd1);
        do_next(MODE_NEXT);
        do_seek(ORD_UPDATE, 1, 64'd7, 64'd3);
        do_seek(3'd6, 1, 64'd7, 64'd3);
        do_next(MODE_NEXT);
        do_next(2'd3);
        drain();
        // snapshot below the page minimum, and UPDATE still finds
        write_reg(CFG_PAGE_MIN, 64'd3);
        do_seek(ORD_GTE, 1, 64'd7, 64'd2);
        do_seek(ORD_UPDATE, 1, 64'd7, 64'd2);

        while (items_sent < 1500) random_phase();
        drain();

        $display("covered %0d items over %0d page settings, %0d results checked",
                 items_sent, phases, sb.results_seen);
        $display("mismatches: %0d, results still expected: %0d", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS snapshot_visible_page_seek");
        end else begin
            $display("FAIL snapshot_visible_page_seek");
        end
        $finish;
    end

endmodule
